FILE: hw/rtl/cdm_pkg.sv
// ----------------------------------------------------------------------------
// cdm_pkg
// shared constants and types for the concentric disk mapping pipeline
// ----------------------------------------------------------------------------
package cdm_pkg;

  localparam int unsigned FRAC = 30;
  localparam int unsigned QW   = 31;   // q1.30 magnitudes up to 1.0
  localparam logic [QW-1:0] ONE_Q  = 31'h4000_0000;
  localparam logic [QW-1:0] PI_4_Q = 31'd843314857;

  // sector index, also the number of quarter turns applied to (cos, sin)
  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  // fixed point multiply, floor(a*b / 2^30)
  function automatic logic [QW-1:0] mulq(input logic [QW-1:0] a, input logic [QW-1:0] b);
    logic [2*QW-1:0] p;
    p = a * b;
    return p[FRAC +: QW];
  endfunction

endpackage

FILE: hw/rtl/cdm_div.sv
// ----------------------------------------------------------------------------
// cdm_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module cdm_div #(
  parameter int unsigned NW = 16,
  parameter int unsigned QB = 31,
  parameter int unsigned TW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i,
  input  logic [NW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic          vld_o,
  output logic [QB-1:0] quo_o,
  output logic [TW-1:0] tag_o
);
  // remainder stays below den, one extra bit for the shift
  logic [NW:0]   rem_q [QB];
  logic [NW-1:0] den_q [QB];
  logic [QB-1:0] quo_q [QB];
  logic [TW-1:0] tag_q [QB];
  logic          vld_q [QB];

  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic [NW+1:0] sh;
    logic [NW+1:0] df;
    logic [NW-1:0] den;
    logic [QB-2:0] quo;
    logic [TW-1:0] tag;
    logic          vld;

    // first stage takes the integer bit, later stages shift in fraction bits
    if (s == 0) begin : g_first
      assign sh  = {2'b00, num_i};
      assign den = den_i;
      assign quo = '0;
      assign tag = tag_i;
      assign vld = vld_i;
    end else begin : g_next
      assign sh  = {rem_q[s-1], 1'b0};
      assign den = den_q[s-1];
      assign quo = quo_q[s-1][QB-2:0];
      assign tag = tag_q[s-1];
      assign vld = vld_q[s-1];
    end

    assign df = sh - {2'b00, den};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s] <= den;
        tag_q[s] <= tag;
        if (!df[NW+1]) begin
          rem_q[s] <= df[NW:0];
          quo_q[s] <= {quo, 1'b1};
        end else begin
          rem_q[s] <= sh[NW:0];
          quo_q[s] <= {quo, 1'b0};
        end
      end
    end
  end

  assign vld_o = vld_q[QB-1];
  assign quo_o = quo_q[QB-1];
  assign tag_o = tag_q[QB-1];
endmodule

FILE: hw/rtl/cdm_trig.sv
// ----------------------------------------------------------------------------
// cdm_trig
// pipelined taylor evaluation of cos and |sin| of the residual angle
// ----------------------------------------------------------------------------
module cdm_trig #(
  parameter int unsigned TW = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  vld_i,
  input  logic [cdm_pkg::QW-1:0] res_i,
  input  logic [TW-1:0]         tag_i,
  output logic                  vld_o,
  output logic [cdm_pkg::QW-1:0] cos_o,
  output logic [cdm_pkg::QW-1:0] sin_o,
  output logic [TW-1:0]         tag_o
);
  import cdm_pkg::*;

  localparam int unsigned NS = 10;
  localparam int unsigned PW = 2*QW + 1;

  // exact floor(n/d) for any QW-bit n as (n*M) >> K, K = QW + ceil(log2 d)
  localparam int unsigned K56 = QW + 6;
  localparam int unsigned K72 = QW + 7;
  localparam int unsigned K30 = QW + 5;
  localparam int unsigned K42 = QW + 6;
  localparam int unsigned K12 = QW + 4;
  localparam int unsigned K20 = QW + 5;
  localparam int unsigned K6  = QW + 3;
  localparam logic [31:0] M56 = 32'(((64'd1 << K56) + 64'd55) / 64'd56);
  localparam logic [31:0] M72 = 32'(((64'd1 << K72) + 64'd71) / 64'd72);
  localparam logic [31:0] M30 = 32'(((64'd1 << K30) + 64'd29) / 64'd30);
  localparam logic [31:0] M42 = 32'(((64'd1 << K42) + 64'd41) / 64'd42);
  localparam logic [31:0] M12 = 32'(((64'd1 << K12) + 64'd11) / 64'd12);
  localparam logic [31:0] M20 = 32'(((64'd1 << K20) + 64'd19) / 64'd20);
  localparam logic [31:0] M6  = 32'(((64'd1 << K6) + 64'd5) / 64'd6);

  logic [NS-1:0] vld_q;
  logic [TW-1:0] tag_q [NS];
  logic [QW-1:0] x_q   [0:8];
  logic [QW-1:0] x2_q  [1:6];
  logic [QW-1:0] c_q   [2:9];
  logic [QW-1:0] s_q   [2:9];

  logic [PW-1:0] pc2, ps2, pc4, ps4, pc6, ps6, ps8;

  // one constant divide per series term, each in its own stage
  assign pc2 = PW'(x2_q[1]) * PW'(M56);
  assign ps2 = PW'(x2_q[1]) * PW'(M72);
  assign pc4 = PW'(c_q[3]) * PW'(M30);
  assign ps4 = PW'(s_q[3]) * PW'(M42);
  assign pc6 = PW'(c_q[5]) * PW'(M12);
  assign ps6 = PW'(s_q[5]) * PW'(M20);
  assign ps8 = PW'(s_q[7]) * PW'(M6);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= mulq(res_i, PI_4_Q);
      tag_q[0] <= tag_i;
      for (int i = 1; i < 9; i++) begin
        x_q[i] <= x_q[i-1];
      end
      for (int i = 1; i < NS; i++) begin
        tag_q[i] <= tag_q[i-1];
      end
      x2_q[1] <= mulq(x_q[0], x_q[0]);
      for (int i = 2; i < 7; i++) begin
        x2_q[i] <= x2_q[i-1];
      end
      // innermost terms
      c_q[2] <= ONE_Q - QW'(pc2 >> K56);
      s_q[2] <= ONE_Q - QW'(ps2 >> K72);
      c_q[3] <= mulq(x2_q[2], c_q[2]);
      s_q[3] <= mulq(x2_q[2], s_q[2]);
      c_q[4] <= ONE_Q - QW'(pc4 >> K30);
      s_q[4] <= ONE_Q - QW'(ps4 >> K42);
      c_q[5] <= mulq(x2_q[4], c_q[4]);
      s_q[5] <= mulq(x2_q[4], s_q[4]);
      c_q[6] <= ONE_Q - QW'(pc6 >> K12);
      s_q[6] <= ONE_Q - QW'(ps6 >> K20);
      c_q[7] <= mulq(x2_q[6], c_q[6]);
      s_q[7] <= mulq(x2_q[6], s_q[6]);
      // outer terms
      c_q[8] <= ONE_Q - {1'b0, c_q[7][QW-1:1]};
      s_q[8] <= ONE_Q - QW'(ps8 >> K6);
      c_q[9] <= c_q[8];
      s_q[9] <= mulq(x_q[8], s_q[8]);
    end
  end

  assign vld_o = vld_q[NS-1];
  assign cos_o = c_q[9];
  assign sin_o = s_q[9];
  assign tag_o = tag_q[NS-1];
endmodule

FILE: hw/rtl/concentric_disk_map.sv
// ----------------------------------------------------------------------------
// concentric_disk_map
// maps unit-square samples to the unit disk by the concentric mapping
// ----------------------------------------------------------------------------
// channel   dir  tdata (low bit first)              handshake
// s_axis    in   sample_x, sample_y                 tvalid/tready
// m_axis    out  disk_x, disk_y (signed)            tvalid/tready
//
// one beat in and one beat out per cycle while the output is not stalled; the pipeline is
// 31 divider stages (one quotient bit each), 10 trig stages,
// the product register and the output register
// reset clears only the valid bits of the pipeline
// the whole pipeline advances only when the output register is free or taken;
// a stall freezes every stage, nothing is lost or repeated
// ----------------------------------------------------------------------------
module concentric_disk_map #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata, // sample_x, sample_y
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata  // disk_x, disk_y
);
  import cdm_pkg::*;

  localparam int unsigned SB  = SAMPLE_BITS;
  localparam int unsigned DW  = ((2*SB+7)/8)*8;
  localparam int unsigned TW  = SB + 1 + 2 + 1 + 1; // radius, quad, neg, zero
  localparam int unsigned RTW = SB + 1 + 2 + 1;     // tag through trig (no zero)

  // global advance: all stages move when the output slot frees up
  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // ---------------- stage 0: sector select ----------------
  logic signed [SB:0] sx, sy, nsx, nsy;
  logic        [SB:0] r0;
  logic        [SB-1:0] num0, den0;
  logic [1:0]  quad0;
  logic        neg0;   // final sign of res
  logic        zero0;  // divisor zero, ratio forced to 0
  logic [SB-1:0] ux, uy;

  assign sx  = $signed({1'b0, s_axis_tdata[SB-1:0]})  - $signed({2'b01, {(SB-1){1'b0}}});
  assign sy  = $signed({1'b0, s_axis_tdata[2*SB-1:SB]}) - $signed({2'b01, {(SB-1){1'b0}}});
  assign nsx = -sx;
  assign nsy = -sy;
  assign ux  = sx[SB] ? nsx[SB-1:0] : sx[SB-1:0];
  assign uy  = sy[SB] ? nsy[SB-1:0] : sy[SB-1:0];

  // magnitudes fit SB bits except full scale 2^(SB-1) which is also SB bits
  always_comb begin
    quad0 = QUAD_3;
    r0    = nsy;
    num0  = ux;
    den0  = uy;
    neg0  = !((sx[SB] != sy[SB])); // res = -ratio(sx,sy)
    zero0 = 1'b0;
    if (sx > nsy) begin
      if (sx > sy) begin
        quad0 = QUAD_0; r0 = sx; num0 = uy; den0 = ux;
        neg0  = (sx[SB] != sy[SB]);
      end else begin
        quad0 = QUAD_1; r0 = sy; num0 = ux; den0 = uy;
        neg0  = !(sx[SB] != sy[SB]);
      end
    end else if (sx < sy) begin
      quad0 = QUAD_2; r0 = nsx; num0 = uy; den0 = ux;
      neg0  = (sx[SB] != sy[SB]);
    end else if (sy == '0) begin
      quad0 = QUAD_0; zero0 = 1'b1;
    end
    if (num0 == '0) neg0 = 1'b0;
    if (den0 == '0) zero0 = 1'b1;
  end

  // ---------------- divider ----------------
  logic           dv_vld;
  logic [QW-1:0]  dv_quo;
  logic [TW-1:0]  dv_tag;

  cdm_div #(.NW(SB), .QB(QW), .TW(TW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid),
    .num_i  (num0),
    .den_i  (zero0 ? {{(SB-1){1'b0}}, 1'b1} : den0),
    .tag_i  ({zero0, neg0, quad0, r0}),
    .vld_o  (dv_vld),
    .quo_o  (dv_quo),
    .tag_o  (dv_tag)
  );

  // quotient is floor(num*2^30/den); clamp and zero forcing
  logic [QW-1:0] res_mag;
  assign res_mag = dv_tag[TW-1] ? '0 : ((dv_quo > ONE_Q) ? ONE_Q : dv_quo);

  // ---------------- trig ----------------
  logic          tg_vld;
  logic [QW-1:0] tg_cos, tg_sin;
  logic [RTW-1:0] tg_tag;

  cdm_trig #(.TW(RTW)) u_trig (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (dv_vld),
    .res_i  (res_mag),
    .tag_i  ({dv_tag[TW-2] && (res_mag != '0), dv_tag[SB+2:0]}),
    .vld_o  (tg_vld),
    .cos_o  (tg_cos),
    .sin_o  (tg_sin),
    .tag_o  (tg_tag)
  );

  // ---------------- rotate and scale ----------------
  logic [SB:0]   rad;
  logic [1:0]    qd;
  logic          sneg;
  logic [QW-1:0] mx, my;
  logic          negx, negy;

  assign rad  = tg_tag[SB:0];
  assign qd   = tg_tag[SB+2:SB+1];
  assign sneg = tg_tag[SB+3];

  always_comb begin
    case (quad_e'(qd))
      QUAD_0: begin mx = tg_cos; negx = 1'b0;  my = tg_sin; negy = sneg;  end
      QUAD_1: begin mx = tg_sin; negx = !sneg; my = tg_cos; negy = 1'b0;  end
      QUAD_2: begin mx = tg_cos; negx = 1'b1;  my = tg_sin; negy = !sneg; end
      default: begin mx = tg_sin; negx = sneg; my = tg_cos; negy = 1'b1;  end
    endcase
    if (mx == '0) negx = 1'b0;
    if (my == '0) negy = 1'b0;
  end

  // product stage registered
  logic [SB+QW:0] px_q, py_q;
  logic           nx_q, ny_q, pv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (en) begin
      pv_q <= tg_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= rad * mx;
      py_q <= rad * my;
      nx_q <= negx;
      ny_q <= negy;
    end
  end

  function automatic logic [SB-1:0] sat(input logic [SB+QW:0] p, input logic n);
    logic [SB+QW:0] m;
    logic [SB+QW:0] half;
    m = (p + (1 << (FRAC-1))) >> FRAC;
    half = {{(QW+1){1'b0}}, 1'b1, {(SB-1){1'b0}}};
    if (!n) begin
      if (m >= half) return half[SB-1:0] - 1'b1;
      return m[SB-1:0];
    end
    if (m >= half) return half[SB-1:0];
    return -m[SB-1:0];
  endfunction

  logic          ov_q;
  logic [DW-1:0] od_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= pv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      od_q <= DW'({sat(py_q, ny_q), sat(px_q, nx_q)});
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;

  // ---------------- checks ----------------
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");
  a_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q && en |=> m_axis_tvalid)
    else $error("product stage lost a beat");
endmodule

FILE: bench/tb_concentric_disk_map.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_concentric_disk_map
// streams unit-square samples through the disk mapping pipeline and compares
// every output beat against a fixed-point predictor kept in the bench
// ----------------------------------------------------------------------------
module tb_concentric_disk_map;
  import cdm_pkg::*;

  localparam int unsigned SB = 16;
  localparam int unsigned DW = ((2*SB+7)/8)*8;
  localparam int unsigned LATENCY = QW + 12;
  localparam int unsigned WATCHDOG = 20000;
  localparam int LONG_HOLD = 200;

  typedef struct packed {
    logic signed [SB-1:0] dy;
    logic signed [SB-1:0] dx;
  } disk_pt_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [DW-1:0] s_axis_tdata = '0;    // sample_x, sample_y
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [DW-1:0] m_axis_tdata;         // disk_x, disk_y

  concentric_disk_map #(.SAMPLE_BITS(SB)) dut (.*);

  initial forever #6 clk_i = ~clk_i;

  disk_pt_t pending_pts[$];
  int mismatches = 0;
  int beats_in = 0;
  int beats_out = 0;
  int idle_cycles = 0;
  bit sink_jitter = 1'b1;
  bit hold_req = 1'b0;  // asks the receiver for one long hold-off
  int sink_hold = 0;    // cycles the receiver must still hold off
  bit src_jitter = 1'b1;

  // ---------------- predictor ----------------
  function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
    return (a * b) >> FRAC;
  endfunction

  // signed q2.30 quotient truncated toward zero and clamped to 1.0, zero on a zero divisor
  function automatic longint quot_q(longint num, longint den);
    logic [63:0] un, ud, q;
    un = num < 0 ? -num : num;
    ud = den < 0 ? -den : den;
    if (ud == 0) return 0;
    q = (un << FRAC) / ud;
    if (q > 64'(ONE_Q)) q = 64'(ONE_Q);
    return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  // round half away from zero, then saturate
  function automatic logic signed [SB-1:0] scale_sat(longint r, longint v);
    longint m;
    longint lim;
    lim = longint'(1) << (SB-1);
    m = longint'((64'(r) * 64'(v < 0 ? -v : v) + (64'd1 << (FRAC-1))) >> FRAC);
    if (v < 0) m = -m;
    if (m > lim - 1) m = lim - 1;
    if (m < -lim) m = -lim;
    return m[SB-1:0];
  endfunction

  function automatic disk_pt_t map_to_disk(logic [SB-1:0] ux, logic [SB-1:0] uy);
    longint sx, sy, r, res, c, s, cx, cy;
    logic [63:0] xm, x2, one, cm, sm;
    quad_e quad;
    disk_pt_t pt;
    sx = longint'(ux) - (longint'(1) << (SB-1));
    sy = longint'(uy) - (longint'(1) << (SB-1));
    if (sx > -sy) begin
      if (sx > sy) begin
        quad = QUAD_0; r = sx; res = quot_q(sy, sx);
      end else begin
        quad = QUAD_1; r = sy; res = -quot_q(sx, sy);
      end
    end else if (sx < sy) begin
      quad = QUAD_2; r = -sx; res = quot_q(sy, sx);
    end else begin
      quad = QUAD_3; r = -sy; res = (sy != 0) ? -quot_q(sx, sy) : 0;
    end
    // origin: angle forced to zero
    if (quad == QUAD_3 && sy == 0) quad = QUAD_0;
    one = 64'(ONE_Q);
    xm = qmul(64'(res < 0 ? -res : res), 64'(PI_4_Q));
    x2 = qmul(xm, xm);
    cm = one - qmul(x2, one - qmul(x2, one - qmul(x2, one - x2/56)/30)/12)/2;
    sm = qmul(xm, one - qmul(x2, one - qmul(x2, one - qmul(x2, one - x2/72)/42)/20)/6);
    c = longint'(cm);
    s = res < 0 ? -longint'(sm) : longint'(sm);
    case (quad)
      QUAD_0: begin cx = c;  cy = s;  end
      QUAD_1: begin cx = -s; cy = c;  end
      QUAD_2: begin cx = -c; cy = -s; end
      default: begin cx = s; cy = -c; end
    endcase
    pt.dx = scale_sat(r, cx);
    pt.dy = scale_sat(r, cy);
    return pt;
  endfunction

  // ---------------- output side ----------------
  // receiver readiness, changed at the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      sink_hold <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_jitter && $urandom_range(0, 3) == 0) begin
      sink_hold <= $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result checker and watchdog, sampled at the rising edge
  always @(posedge clk_i) begin
    disk_pt_t got, want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[2*SB-1:0];
        beats_out <= beats_out + 1;
        if (pending_pts.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected output beat %h", got);
        end else begin
          want = pending_pts.pop_front();
          if (got.dx !== want.dx || got.dy !== want.dy) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("beat %0d: expected x=%0d y=%0d, got x=%0d y=%0d",
                       beats_out, want.dx, want.dy, got.dx, got.dy);
          end
        end
      end
    end
  end

  // ---------------- input side ----------------
  task automatic send_sample(logic [SB-1:0] ux, logic [SB-1:0] uy);
    int gap;
    if (src_jitter && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata <= '0;
    s_axis_tdata[2*SB-1:0] <= {uy, ux};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_pts = {pending_pts, map_to_disk(ux, uy)};
    beats_in++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_pts.size() != 0) @(negedge clk_i);
  endtask

  localparam logic [SB-1:0] MID = {1'b1, {(SB-1){1'b0}}};

  // corners, axes, diagonals, origin and full-scale radius
  task automatic test_directed();
    logic [SB-1:0] pts[16][2] = '{
      '{MID, MID}, '{16'h0000, 16'h0000}, '{16'hFFFF, 16'hFFFF},
      '{16'h0000, 16'hFFFF}, '{16'hFFFF, 16'h0000}, '{16'h0000, MID},
      '{MID, 16'h0000}, '{16'hFFFF, MID}, '{MID, 16'hFFFF},
      '{16'h5555, 16'hAAAA}, '{16'hAAAA, 16'h5555}, '{MID+1, MID},
      '{MID, MID-1}, '{MID-1, MID}, '{16'h0001, 16'hFFFE}, '{16'hC000, 16'h4000}};
    foreach (pts[i]) send_sample(pts[i][0], pts[i][1]);
    drain();
  endtask

  // full-range points half the time, the rest on the diagonals or near the center
  task automatic test_random(int n);
    logic [SB-1:0] ux, uy;
    int d;
    repeat (n) begin
      ux = SB'($urandom);
      uy = SB'($urandom);
      case ($urandom_range(0, 5))
        0: uy = ux;
        1: uy = -ux;
        2: begin
          d = $urandom_range(0, 8);
          ux = SB'(int'(MID) + d - 4);
          uy = SB'(int'(MID) + int'($urandom_range(0, 8)) - 4);
        end
        default: ;
      endcase
      send_sample(ux, uy);
    end
  endtask

  // receiver holds off while the sender keeps offering, so input stalls
  task automatic test_backpressure();
    hold_req = 1'b1;
    test_random(150);
    drain();
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(600);
    test_backpressure();
    test_random(400);
    drain();   // sender pauses until all results are back
    src_jitter = 1'b0;
    sink_jitter = 1'b0;
    test_random(150);
    drain();
    repeat (LATENCY + 8) @(negedge clk_i);
    $display("sent %0d samples, checked %0d disk points, incl. axes, diagonals,", beats_in,
             beats_out);
    $display("origin, full-scale radius and a long output stall");
    if (mismatches == 0 && pending_pts.size() == 0)
      $display("tb_concentric_disk_map OK");
    else
      $display("tb_concentric_disk_map NOT OK");
    $finish;
  end

  initial begin
    wait (rst_ni);
    wait (idle_cycles >= WATCHDOG);
    $display("watchdog expired");
    $display("tb_concentric_disk_map NOT OK");
    $finish;
  end

endmodule
